### rtl/core/bptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_pkg
// shared widths, register map, reset values and output bounds
// ----------------------------------------------------------------------------
package bptc_pkg;

	localparam int unsigned RAW_W   = 24;
	localparam int unsigned CAL_W   = 16;
	localparam int unsigned PRESS_W = 17;
	localparam int unsigned TEMP_W  = 15;
	localparam int unsigned APB_AW  = 5;
	localparam int unsigned APB_DW  = 32;

	// register indexes, byte address is 4 * index
	localparam logic [2:0] REG_C1 = 3'd0;
	localparam logic [2:0] REG_C2 = 3'd1;
	localparam logic [2:0] REG_C3 = 3'd2;
	localparam logic [2:0] REG_C4 = 3'd3;
	localparam logic [2:0] REG_C5 = 3'd4;
	localparam logic [2:0] REG_C6 = 3'd5;

	localparam logic [CAL_W-1:0] C1_RST = 16'd40127;
	localparam logic [CAL_W-1:0] C2_RST = 16'd36924;
	localparam logic [CAL_W-1:0] C3_RST = 16'd23317;
	localparam logic [CAL_W-1:0] C4_RST = 16'd23282;
	localparam logic [CAL_W-1:0] C5_RST = 16'd33464;
	localparam logic [CAL_W-1:0] C6_RST = 16'd28312;

	// temperature thresholds in 0.01 C
	localparam int TEMP_REF  = 2000;
	localparam int TEMP_VLOW = -1500;

	// output range
	localparam int P_MIN = 1000;
	localparam int P_MAX = 120000;
	localparam int T_MIN = -4000;
	localparam int T_MAX = 8500;

endpackage

### rtl/core/bptc_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_sample_if
// raw conversion pair channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface bptc_sample_if import bptc_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_pressure;
	logic [RAW_W-1:0] raw_temperature;

	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);

endinterface

### rtl/core/bptc_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_result_if
// compensated result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface bptc_result_if import bptc_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic [PRESS_W-1:0]       pressure_pa;
	logic signed [TEMP_W-1:0] temp_centi;
	logic                     clamped;

	modport source (output valid, output pressure_pa, output temp_centi, output clamped,
		input ready);
	modport sink   (input valid, input pressure_pa, input temp_centi, input clamped,
		output ready);

endinterface

### rtl/core/baro_pressure_temp_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// second-order barometer pressure and temperature compensation pipeline
// ----------------------------------------------------------------------------
// throughput: one word per cycle; each stage holds one word and has its own
// valid bit, so a stalled output only blocks once every stage ahead is full
// reset (arst_n low, asynchronous): all stage valid bits clear, calibration
// registers return to their factory defaults
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation import bptc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// apb configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	// word channels
	bptc_sample_if.sink       sample,
	bptc_result_if.source     result
);

	localparam int unsigned STAGES = 10;

	// ------------------------------------------------------------------
	// calibration registers
	// ------------------------------------------------------------------
	logic [CAL_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	logic             cfg_wr;
	logic [2:0]       cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= C1_RST;
			c2_q <= C2_RST;
			c3_q <= C3_RST;
			c4_q <= C4_RST;
			c5_q <= C5_RST;
			c6_q <= C6_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_C1: c1_q <= pwdata[CAL_W-1:0];
				REG_C2: c2_q <= pwdata[CAL_W-1:0];
				REG_C3: c3_q <= pwdata[CAL_W-1:0];
				REG_C4: c4_q <= pwdata[CAL_W-1:0];
				REG_C5: c5_q <= pwdata[CAL_W-1:0];
				REG_C6: c6_q <= pwdata[CAL_W-1:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	// read back
	always_comb begin
		case (cfg_idx)
			REG_C1: prdata = {{(APB_DW-CAL_W){1'b0}}, c1_q};
			REG_C2: prdata = {{(APB_DW-CAL_W){1'b0}}, c2_q};
			REG_C3: prdata = {{(APB_DW-CAL_W){1'b0}}, c3_q};
			REG_C4: prdata = {{(APB_DW-CAL_W){1'b0}}, c4_q};
			REG_C5: prdata = {{(APB_DW-CAL_W){1'b0}}, c5_q};
			REG_C6: prdata = {{(APB_DW-CAL_W){1'b0}}, c6_q};
			default: prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// stage valid bits and per-stage advance
	// a stage may take a new word when it is empty or its own word moves on
	// ------------------------------------------------------------------
	logic [STAGES:1] vld_q;
	logic [STAGES:1] adv;
	logic [STAGES:1] vprev;
	logic [STAGES:1] load;

	always_comb begin
		adv[STAGES] = !vld_q[STAGES] || result.ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
		vprev = {vld_q[STAGES-1:1], sample.valid};
		load  = adv & vprev;
	end

	assign sample.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vprev[k];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// datapath
	// ------------------------------------------------------------------
	localparam logic signed [18:0] TEMP_REF_C  = 19'(TEMP_REF);
	// temp < vlow threshold, tested on the offset x = temp - 2000
	localparam logic signed [17:0] X_VLOW_C    = 18'(TEMP_VLOW - TEMP_REF);
	localparam logic signed [18:0] Y_OFS_C     = 19'(TEMP_REF - TEMP_VLOW);
	localparam logic signed [32:0] P_MIN_C     = 33'(P_MIN);
	localparam logic signed [32:0] P_MAX_C     = 33'(P_MAX);
	localparam logic signed [19:0] T_MIN_C     = 20'(T_MIN);
	localparam logic signed [19:0] T_MAX_C     = 20'(T_MAX);

	// s1: dT = D2 - C5*256
	logic signed [24:0] dt_s1;
	logic [RAW_W-1:0]   d1_s1;

	// s2: the four first-order products
	logic signed [41:0] dtc6_s2, c4dt_s2, c3dt_s2;
	logic [17:0]        t2_s2;
	logic [RAW_W-1:0]   d1_s2;
	logic signed [41:0] dtc6_w, c4dt_w, c3dt_w;
	logic signed [49:0] dtdt_w;

	assign dtc6_w = dt_s1 * $signed({1'b0, c6_q});
	assign c4dt_w = dt_s1 * $signed({1'b0, c4_q});
	assign c3dt_w = dt_s1 * $signed({1'b0, c3_q});
	assign dtdt_w = dt_s1 * dt_s1;

	// s3: first-order temp, off, sens and the low-temperature flags
	logic signed [17:0] x_s3;   // temp - 2000
	logic signed [18:0] y_s3;   // temp + 1500
	logic signed [18:0] temp_s3;
	logic signed [41:0] off_s3, sens_s3;
	logic [17:0]        t2_s3;
	logic               low_s3, vlow_s3;
	logic [RAW_W-1:0]   d1_s3;
	logic signed [17:0] x_w;

	assign x_w = $signed(dtc6_s2[40:23]);

	// s4: squares
	logic [35:0]        a_s4, b_s4;
	logic signed [18:0] temp_s4;
	logic signed [41:0] off_s4, sens_s4;
	logic [17:0]        t2_s4;
	logic               low_s4, vlow_s4;
	logic [RAW_W-1:0]   d1_s4;
	logic signed [35:0] a_w;
	logic signed [37:0] b_w;

	assign a_w = x_s3 * x_s3;
	assign b_w = y_s3 * y_s3;

	// s5: second-order corrections
	logic [39:0]        off2_s5, sens2_s5;
	logic signed [18:0] temp_s5;
	logic signed [41:0] off_s5, sens_s5;
	logic [17:0]        t2_s5;
	logic               low_s5;
	logic [RAW_W-1:0]   d1_s5;
	logic [39:0]        a5_w, b7_w, b11_w;

	assign a5_w  = {2'b00, a_s4, 2'b00} + {4'b0000, a_s4};
	assign b7_w  = {1'b0, b_s4, 3'b000} - {4'b0000, b_s4};
	assign b11_w = {1'b0, b_s4, 3'b000} + {3'b000, b_s4, 1'b0} + {4'b0000, b_s4};

	// s6: corrected temp, off, sens
	logic signed [19:0] temp_s6;
	logic signed [41:0] off_s6, sens_s6;
	logic [RAW_W-1:0]   d1_s6;

	// s7: D1 * SENS as two partial products, sens split at bit 21
	logic [44:0]        pplo_s7;
	logic signed [45:0] pphi_s7;
	logic signed [19:0] temp_s7;
	logic signed [41:0] off_s7;
	logic signed [45:0] pphi_w;

	assign pphi_w = $signed({1'b0, d1_s6}) * $signed(sens_s6[41:21]);

	// s8: (D1 * SENS) >> 21, low part only feeds its carry bits
	logic signed [46:0] q_s8;
	logic signed [19:0] temp_s8;
	logic signed [41:0] off_s8;

	// s9: P before saturation
	logic signed [32:0] p_s9;
	logic signed [19:0] temp_s9;
	logic signed [47:0] pdiff_w;

	assign pdiff_w = 48'(q_s8) - 48'(off_s8);

	// s10: saturated output word
	logic [PRESS_W-1:0]       press_s10;
	logic signed [TEMP_W-1:0] temp_s10;
	logic                     clamped_s10;

	always_ff @(posedge clk) begin
		if (load[1]) begin
			dt_s1 <= $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, c5_q, 8'h00});
			d1_s1 <= sample.raw_pressure;
		end
		if (load[2]) begin
			dtc6_s2 <= dtc6_w;
			c4dt_s2 <= c4dt_w;
			c3dt_s2 <= c3dt_w;
			t2_s2   <= dtdt_w[48:31];
			d1_s2   <= d1_s1;
		end
		if (load[3]) begin
			x_s3    <= x_w;
			y_s3    <= 19'(x_w) + Y_OFS_C;
			temp_s3 <= 19'(x_w) + TEMP_REF_C;
			off_s3  <= $signed({10'd0, c2_q, 16'h0000}) + (c4dt_s2 >>> 7);
			sens_s3 <= $signed({11'd0, c1_q, 15'h0000}) + (c3dt_s2 >>> 8);
			t2_s3   <= t2_s2;
			low_s3  <= x_w[17];
			vlow_s3 <= x_w < X_VLOW_C;
			d1_s3   <= d1_s2;
		end
		if (load[4]) begin
			a_s4    <= a_w[35:0];
			b_s4    <= b_w[35:0];
			temp_s4 <= temp_s3;
			off_s4  <= off_s3;
			sens_s4 <= sens_s3;
			t2_s4   <= t2_s3;
			low_s4  <= low_s3;
			vlow_s4 <= vlow_s3;
			d1_s4   <= d1_s3;
		end
		if (load[5]) begin
			// extra term only below the very-low threshold
			off2_s5  <= (a5_w >> 1) + (vlow_s4 ? b7_w : 40'd0);
			sens2_s5 <= (a5_w >> 2) + (vlow_s4 ? (b11_w >> 1) : 40'd0);
			temp_s5  <= temp_s4;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			t2_s5    <= t2_s4;
			low_s5   <= low_s4;
			d1_s5    <= d1_s4;
		end
		if (load[6]) begin
			if (low_s5) begin
				temp_s6 <= 20'(temp_s5) - $signed({2'b00, t2_s5});
				off_s6  <= off_s5 - $signed({2'b00, off2_s5});
				sens_s6 <= sens_s5 - $signed({2'b00, sens2_s5});
			end else begin
				temp_s6 <= 20'(temp_s5);
				off_s6  <= off_s5;
				sens_s6 <= sens_s5;
			end
			d1_s6 <= d1_s5;
		end
		if (load[7]) begin
			pplo_s7 <= d1_s6 * sens_s6[20:0];
			pphi_s7 <= pphi_w;
			temp_s7 <= temp_s6;
			off_s7  <= off_s6;
		end
		if (load[8]) begin
			q_s8    <= 47'(pphi_s7) + $signed({23'd0, pplo_s7[44:21]});
			temp_s8 <= temp_s7;
			off_s8  <= off_s7;
		end
		if (load[9]) begin
			p_s9    <= pdiff_w[47:15];
			temp_s9 <= temp_s8;
		end
		if (load[10]) begin
			if (p_s9 < P_MIN_C) begin
				press_s10 <= PRESS_W'(P_MIN);
			end else if (p_s9 > P_MAX_C) begin
				press_s10 <= PRESS_W'(P_MAX);
			end else begin
				press_s10 <= p_s9[PRESS_W-1:0];
			end
			if (temp_s9 < T_MIN_C) begin
				temp_s10 <= TEMP_W'(T_MIN);
			end else if (temp_s9 > T_MAX_C) begin
				temp_s10 <= TEMP_W'(T_MAX);
			end else begin
				temp_s10 <= temp_s9[TEMP_W-1:0];
			end
			clamped_s10 <= (p_s9 < P_MIN_C) || (p_s9 > P_MAX_C) ||
				(temp_s9 < T_MIN_C) || (temp_s9 > T_MAX_C);
		end
	end

	assign result.valid       = vld_q[STAGES];
	assign result.pressure_pa = press_s10;
	assign result.temp_centi  = temp_s10;
	assign result.clamped     = clamped_s10;

endmodule

### rtl/core/bptc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
module bptc_checker import bptc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic [PRESS_W-1:0]       res_pressure,
	input logic signed [TEMP_W-1:0] res_temp,
	input logic                     res_clamped
);

	// a stalled word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_pressure) &&
		$stable(res_temp) && $stable(res_clamped))
		else $error("result word changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_pressure >= PRESS_W'(P_MIN) && res_pressure <= PRESS_W'(P_MAX))
		else $error("pressure out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_temp >= TEMP_W'(T_MIN) && res_temp <= TEMP_W'(T_MAX))
		else $error("temperature out of range");

	// clamp flag only when a value sits on a bound
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_clamped |->
		res_pressure == PRESS_W'(P_MIN) || res_pressure == PRESS_W'(P_MAX) ||
		res_temp == TEMP_W'(T_MIN) || res_temp == TEMP_W'(T_MAX))
		else $error("clamp flag without saturated value");

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_pressure (result.pressure_pa),
	.res_temp     (result.temp_centi),
	.res_clamped  (result.clamped)
);

### sim/bptc_compensation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_compensation_checker
// Watches the configuration port and both word channels. It keeps its own copy
// of the six calibration words and computes the compensated reading for every
// accepted sample word in signed 64-bit arithmetic. Each result word is
// compared field by field with the oldest reading still waiting.
// ----------------------------------------------------------------------------
module bptc_compensation_checker import bptc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	bptc_sample_if            sample,
	bptc_result_if            result,
	output int unsigned       errors,
	output int unsigned       outstanding,
	output int unsigned       words_in,
	output int unsigned       words_out,
	output int unsigned       cold_words,
	output int unsigned       very_cold_words,
	output int unsigned       clamped_words
);

	typedef struct packed {
		logic [PRESS_W-1:0]       pressure_pa;
		logic signed [TEMP_W-1:0] temp_centi;
		logic                     clamped;
	} reading_t;

	typedef enum int unsigned {BAND_WARM, BAND_COLD, BAND_VERY_COLD} band_t;

	logic [CAL_W-1:0] cal [6];
	reading_t         expected_readings [$];

	function automatic reading_t compensate(input logic [RAW_W-1:0] d1,
		input logic [RAW_W-1:0] d2, output band_t band);
		longint   dt, temp, off, sens, p, t2, a, b, off2, sens2;
		reading_t r;
		band = BAND_WARM;
		dt   = longint'(d2) - longint'(cal[REG_C5]) * 256;
		temp = TEMP_REF + ((dt * longint'(cal[REG_C6])) >>> 23);
		off  = longint'(cal[REG_C2]) * 65536 + ((longint'(cal[REG_C4]) * dt) >>> 7);
		sens = longint'(cal[REG_C1]) * 32768 + ((longint'(cal[REG_C3]) * dt) >>> 8);
		// both band tests look at the first-order temperature
		if (temp < TEMP_REF) begin
			band  = BAND_COLD;
			t2    = (dt * dt) >>> 31;
			a     = (temp - TEMP_REF) * (temp - TEMP_REF);
			off2  = (5 * a) >>> 1;
			sens2 = (5 * a) >>> 2;
			if (temp < TEMP_VLOW) begin
				band  = BAND_VERY_COLD;
				b     = (temp - TEMP_VLOW) * (temp - TEMP_VLOW);
				off2  = off2 + 7 * b;
				sens2 = sens2 + ((11 * b) >>> 1);
			end
			temp = temp - t2;
			off  = off - off2;
			sens = sens - sens2;
		end
		p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
		r.clamped = 1'b0;
		if (p < P_MIN) begin
			p = P_MIN;
			r.clamped = 1'b1;
		end else if (p > P_MAX) begin
			p = P_MAX;
			r.clamped = 1'b1;
		end
		if (temp < T_MIN) begin
			temp = T_MIN;
			r.clamped = 1'b1;
		end else if (temp > T_MAX) begin
			temp = T_MAX;
			r.clamped = 1'b1;
		end
		r.pressure_pa = p[PRESS_W-1:0];
		r.temp_centi  = temp[TEMP_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t    want;
		reading_t    got;
		band_t       band;
		int unsigned pushed;
		int unsigned popped;
		int unsigned fails;
		if (!arst_n) begin
			cal[REG_C1] <= C1_RST;
			cal[REG_C2] <= C2_RST;
			cal[REG_C3] <= C3_RST;
			cal[REG_C4] <= C4_RST;
			cal[REG_C5] <= C5_RST;
			cal[REG_C6] <= C6_RST;
			expected_readings.delete();
			errors          <= 0;
			outstanding     <= 0;
			words_in        <= 0;
			words_out       <= 0;
			cold_words      <= 0;
			very_cold_words <= 0;
			clamped_words   <= 0;
		end else begin
			pushed = 0;
			popped = 0;
			fails  = 0;
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
					REG_C1, REG_C2, REG_C3, REG_C4, REG_C5, REG_C6:
						cal[paddr[APB_AW-1:2]] <= pwdata[CAL_W-1:0];
					default: ;
				endcase
			end
			if (sample.valid && sample.ready) begin
				want = compensate(sample.raw_pressure, sample.raw_temperature, band);
				expected_readings.push_back(want);
				pushed = 1;
				words_in <= words_in + 1;
				if (band != BAND_WARM)
					cold_words <= cold_words + 1;
				if (band == BAND_VERY_COLD)
					very_cold_words <= very_cold_words + 1;
				if (want.clamped)
					clamped_words <= clamped_words + 1;
			end
			if (result.valid && result.ready) begin
				got.pressure_pa = result.pressure_pa;
				got.temp_centi  = result.temp_centi;
				got.clamped     = result.clamped;
				words_out <= words_out + 1;
				if (expected_readings.size() == 0) begin
					fails++;
					$display("%0t unexpected result word: expected none, got %0d Pa %0d cC clamp %0d",
						$time, got.pressure_pa, got.temp_centi, got.clamped);
				end else begin
					want   = expected_readings.pop_front();
					popped = 1;
					if (got.pressure_pa !== want.pressure_pa) begin
						fails++;
						$display("%0t pressure_pa mismatch: expected %0d, got %0d",
							$time, want.pressure_pa, got.pressure_pa);
					end
					if (got.temp_centi !== want.temp_centi) begin
						fails++;
						$display("%0t temp_centi mismatch: expected %0d, got %0d",
							$time, want.temp_centi, got.temp_centi);
					end
					if (got.clamped !== want.clamped) begin
						fails++;
						$display("%0t clamped mismatch: expected %0d, got %0d",
							$time, want.clamped, got.clamped);
					end
				end
			end
			errors      <= errors + fails;
			outstanding <= outstanding + pushed - popped;
		end
	end

endmodule

### sim/tb_baro_pressure_temp_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_baro_pressure_temp_compensation
// Drives the compensation pipeline with raw conversion pairs under a series of
// calibration settings and gives the verdict. A checker beside the block
// predicts every result word and compares it; this module makes the stimulus,
// the output back-pressure and the watchdog.
// ----------------------------------------------------------------------------
module tb_baro_pressure_temp_compensation import bptc_pkg::*; ();

	// register slots past the calibration words, writes there must be dropped
	localparam logic [2:0]  REG_SPARE_LO    = 3'd6;
	localparam logic [2:0]  REG_SPARE_HI    = 3'd7;
	localparam int unsigned RANDOM_PHASES   = 7;
	localparam int unsigned WORDS_PER_PHASE = 105;
	// half-width of the raw temperature window around the reference point
	localparam longint      TEMP_SPAN       = 2097152;
	localparam int unsigned RAW_MAX         = 24'hFFFFFF;
	localparam int unsigned PIPE_LATENCY    = 10;
	localparam int unsigned LONG_HOLD       = 100;
	localparam int unsigned HOLD_AFTER      = 300;
	localparam int unsigned WATCHDOG_LIMIT  = 2000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              no_idle;

	// calibration words as last written, used to aim the raw temperature
	logic [CAL_W-1:0]  cal_set [6];

	int unsigned errors;
	int unsigned outstanding;
	int unsigned words_in;
	int unsigned words_out;
	int unsigned cold_words;
	int unsigned very_cold_words;
	int unsigned clamped_words;

	bptc_sample_if sample_ch ();
	bptc_result_if result_ch ();

	baro_pressure_temp_compensation dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sample  (sample_ch),
		.result  (result_ch)
	);

	bptc_compensation_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.sample          (sample_ch),
		.result          (result_ch),
		.errors          (errors),
		.outstanding     (outstanding),
		.words_in        (words_in),
		.words_out       (words_out),
		.cold_words      (cold_words),
		.very_cold_words (very_cold_words),
		.clamped_words   (clamped_words)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one apb write: setup phase, then access phase until pready, then back to idle
	task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// upper half of the data bus carries junk, only the low 16 bits count
	task automatic program_cal(input logic [CAL_W-1:0] c1, input logic [CAL_W-1:0] c2,
		input logic [CAL_W-1:0] c3, input logic [CAL_W-1:0] c4,
		input logic [CAL_W-1:0] c5, input logic [CAL_W-1:0] c6);
		write_reg(REG_C1, {16'($urandom), c1});
		write_reg(REG_C2, {16'($urandom), c2});
		write_reg(REG_C3, {16'($urandom), c3});
		write_reg(REG_C4, {16'($urandom), c4});
		write_reg(REG_C5, {16'($urandom), c5});
		write_reg(REG_C6, {16'($urandom), c6});
		// slots past the map must not disturb anything
		write_reg(REG_SPARE_LO, $urandom);
		write_reg(REG_SPARE_HI, $urandom);
		cal_set[REG_C1] = c1;
		cal_set[REG_C2] = c2;
		cal_set[REG_C3] = c3;
		cal_set[REG_C4] = c4;
		cal_set[REG_C5] = c5;
		cal_set[REG_C6] = c6;
	endtask

	// drain the pipeline before touching the calibration
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2)
			@(posedge clk);
	endtask

	// offer one sample word, maybe after a burst of idle cycles
	task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
		end
		sample_ch.valid           <= 1'b1;
		sample_ch.raw_pressure    <= d1;
		sample_ch.raw_temperature <= d2;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
	endtask

	// mostly plausible readings around the reference temperature, some anywhere
	task automatic send_random_reading();
		int unsigned      pick;
		longint           d2_wide;
		logic [RAW_W-1:0] d1;
		pick    = $urandom_range(0, 9);
		d2_wide = longint'(cal_set[REG_C5]) * 256
			+ longint'($urandom_range(0, 2 * TEMP_SPAN)) - TEMP_SPAN;
		if (d2_wide < 0)
			d2_wide = 0;
		if (d2_wide > RAW_MAX)
			d2_wide = RAW_MAX;
		if (pick < 2)
			d2_wide = longint'($urandom_range(0, RAW_MAX));
		// this band of raw pressure lands inside the range for typical words
		if (pick < 7)
			d1 = RAW_W'($urandom_range(3500000, 10500000));
		else
			d1 = RAW_W'($urandom);
		send_reading(d1, d2_wide[RAW_W-1:0]);
	endtask

	// stimulus
	initial begin
		sample_ch.valid           <= 1'b0;
		sample_ch.raw_pressure    <= '0;
		sample_ch.raw_temperature <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		no_idle <= 1'b0;
		cal_set[REG_C1] = C1_RST;
		cal_set[REG_C2] = C2_RST;
		cal_set[REG_C3] = C3_RST;
		cal_set[REG_C4] = C4_RST;
		cal_set[REG_C5] = C5_RST;
		cal_set[REG_C6] = C6_RST;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// factory defaults straight out of reset
		send_reading(24'd9085466, 24'd8569150);     // typical room reading
		send_reading(24'd0, 24'd0);
		send_reading(24'hFFFFFF, 24'hFFFFFF);
		send_reading(24'd0, 24'hFFFFFF);
		send_reading(24'hFFFFFF, 24'd0);
		send_reading(24'd9085466, 24'd8566784);     // exactly 20.00 C, no correction
		send_reading(24'd9085466, 24'd8566783);     // one step colder, correction kicks in

		// with C5 and C6 at 2^15 the temperature is 2000 + dT/256, so the
		// band edges fall on exact raw values
		settle();
		program_cal(C1_RST, C2_RST, C3_RST, C4_RST, 16'd32768, 16'd32768);
		send_reading(24'd9085466, 24'd8388608);     // 20.00 C
		send_reading(24'd9085466, 24'd8388607);     // 19.99 C
		send_reading(24'd9085466, 24'd7492608);     // -15.00 C, cold band only
		send_reading(24'd9085466, 24'd7492607);     // -15.01 C, extra term too
		send_reading(24'd9085466, 24'hFFFFFF);      // temperature saturates high
		send_reading(24'd9085466, 24'd0);           // temperature saturates low
		send_reading(24'd0, 24'd8388608);           // pressure saturates low
		send_reading(24'hFFFFFF, 24'd8388608);      // pressure saturates high

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			case (ph)
				0: program_cal(C1_RST, C2_RST, C3_RST, C4_RST, C5_RST, C6_RST);
				1: program_cal('0, '0, '0, '0, '0, '0);
				2: program_cal('1, '1, '1, '1, '1, '1);
				3: program_cal(CAL_W'($urandom), CAL_W'($urandom), CAL_W'($urandom),
					CAL_W'($urandom), '0, '1);
				4: program_cal(CAL_W'($urandom), CAL_W'($urandom), CAL_W'($urandom),
					CAL_W'($urandom), '1, '0);
				default: program_cal(CAL_W'($urandom), CAL_W'($urandom), CAL_W'($urandom),
					CAL_W'($urandom), CAL_W'($urandom), CAL_W'($urandom));
			endcase
			// last setting runs flat out on both sides
			if (ph == RANDOM_PHASES - 1)
				no_idle <= 1'b1;
			repeat (WORDS_PER_PHASE)
				send_random_reading();
		end
		sample_ch.valid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (2 * PIPE_LATENCY)
			@(posedge clk);

		$display("%0d result words checked over %0d calibration settings", words_out,
			RANDOM_PHASES + 2);
		$display("%0d below 20 C, %0d below -15 C, %0d saturated, one %0d-cycle output stall",
			cold_words, very_cold_words, clamped_words, LONG_HOLD);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// result side: random stall bursts, plus one long hold-off so the pipe
	// fills and pushes back on the sample channel
	initial begin
		int unsigned gap;
		int unsigned hold;
		bit          held;
		gap  = 0;
		hold = 0;
		held = 1'b0;
		result_ch.ready <= 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!held && words_in >= HOLD_AFTER) begin
				held = 1'b1;
				hold = LONG_HOLD;
			end
			if (hold != 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else if (gap != 0) begin
				gap--;
				result_ch.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(0, 7);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
			@(posedge clk);
		end
	end

	// watchdog: too long without any word or register access moving
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

endmodule
